@@ src/fnorm_pkg.sv @@
// Shared types, constants and tables of the feature normalizer.
`timescale 1ns / 1ps
package fnorm_pkg;

  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_LINEAR  = 3'd1,
    MODE_SIGMOID = 3'd2,
    MODE_DSIG    = 3'd3,
    MODE_ZSCORE  = 3'd4,
    MODE_IQZ     = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_MIN   = 3'd1,
    REG_MAX   = 3'd2,
    REG_MEAN  = 3'd3,
    REG_SIGMA = 3'd4,
    REG_MED   = 3'd5,
    REG_QLOW  = 3'd6,
    REG_QHIGH = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_LIN = 2'd0,
    KIND_Z   = 2'd1,
    KIND_SIG = 2'd2
  } kind_e;

  localparam int Q_W        = 32;
  localparam int EXP_BITS   = 21;
  localparam int DIV_NUM_W  = 52;
  localparam int DIV_DEN_W  = 33;
  localparam int REC_NUM_W  = 17;
  localparam int REC_DEN_W  = 34;
  localparam int SHIFT_LIN  = 16;
  localparam int SHIFT_Z    = 13;
  localparam int SHIFT_SIG  = 19;

  localparam logic signed [31:0] Q_ONE   = 32'sd65536;
  localparam logic signed [31:0] Q_HALF  = 32'sd32768;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;
  localparam logic [20:0]        U_LIMIT = 21'd1048576;

  localparam logic [31:0] EXP_TAB [EXP_BITS] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
    32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
    32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
    32'd2605029347, 32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801,
    32'd483
  };

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] stat_minimum;
    logic signed [31:0] stat_maximum;
    logic signed [31:0] stat_mean;
    logic signed [31:0] stat_sigma;
    logic signed [31:0] stat_median;
    logic signed [31:0] quantile_low;
    logic signed [31:0] quantile_high;
  } cfg_t;

  typedef struct packed {
    logic               bypass;
    logic signed [31:0] byp_val;
    logic               fault;
    kind_e              kind;
    logic               neg;
  } side_t;

  localparam int SIDE_BITS = $bits(side_t);

  typedef struct packed {
    logic               fin;
    logic               fault;
    logic               tneg;
    logic signed [31:0] val;
    logic [20:0]        u;
  } mid_t;

  localparam int LATENCY = 2 + DIV_NUM_W + 1 + EXP_BITS + 1 + REC_NUM_W + 1;

endpackage

@@ src/fnorm_cfg.sv @@
// Configuration register bank.
`timescale 1ns / 1ps
module fnorm_cfg import fnorm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= MODE_NONE;
      cfg_q.stat_minimum  <= '0;
      cfg_q.stat_maximum  <= Q_ONE;
      cfg_q.stat_mean     <= '0;
      cfg_q.stat_sigma    <= Q_ONE;
      cfg_q.stat_median   <= '0;
      cfg_q.quantile_low  <= '0;
      cfg_q.quantile_high <= Q_ONE;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MODE:  cfg_q.mode          <= cfg_data_i[2:0];
        REG_MIN:   cfg_q.stat_minimum  <= cfg_data_i;
        REG_MAX:   cfg_q.stat_maximum  <= cfg_data_i;
        REG_MEAN:  cfg_q.stat_mean     <= cfg_data_i;
        REG_SIGMA: cfg_q.stat_sigma    <= cfg_data_i;
        REG_MED:   cfg_q.stat_median   <= cfg_data_i;
        REG_QLOW:  cfg_q.quantile_low  <= cfg_data_i;
        REG_QHIGH: cfg_q.quantile_high <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

@@ src/fnorm_front.sv @@
// Two setup stages: difference, divisor, magnitudes and special cases.
`timescale 1ns / 1ps
module fnorm_front import fnorm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [31:0]   sample_i,
  input  cfg_t                 cfg_i,
  output logic                 valid_o,
  output logic [DIV_NUM_W-1:0] num_o,
  output logic [DIV_DEN_W-1:0] den_o,
  output side_t                side_o
);

  logic               v1_q;
  logic [2:0]         mode1_q, mode1_d;
  logic signed [31:0] x1_q;
  logic signed [32:0] d1_q, d1_d, r1_q, r1_d;
  logic               ident1_q, ident1_d;

  logic signed [32:0] xe, mne, mxe, meane, sige, mede, qle, qhe;

  assign xe    = 33'(sample_i);
  assign mne   = 33'(cfg_i.stat_minimum);
  assign mxe   = 33'(cfg_i.stat_maximum);
  assign meane = 33'(cfg_i.stat_mean);
  assign sige  = 33'(cfg_i.stat_sigma);
  assign mede  = 33'(cfg_i.stat_median);
  assign qle   = 33'(cfg_i.quantile_low);
  assign qhe   = 33'(cfg_i.quantile_high);

  always_comb begin
    mode1_d  = cfg_i.mode;
    ident1_d = (cfg_i.stat_minimum == '0) && (cfg_i.stat_maximum == Q_ONE);
    d1_d     = xe - mede;
    r1_d     = qhe - qle;
    unique case (mode_e'(cfg_i.mode))
      MODE_LINEAR: begin
        d1_d = xe - mne;
        r1_d = mxe - mne;
      end
      MODE_DSIG:   r1_d = (xe > mede) ? (qhe - mede) : (mede - qle);
      MODE_ZSCORE: begin
        d1_d = xe - meane;
        r1_d = sige;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mode1_q  <= mode1_d;
    x1_q     <= sample_i;
    d1_q     <= d1_d;
    r1_q     <= r1_d;
    ident1_q <= ident1_d;
  end

  logic [32:0]          mag_d, mag_r;
  logic                 dpos, dneg, rzero;
  logic [DIV_NUM_W-1:0] num_base, num_d;
  side_t                side_d;
  logic                 v2_q;
  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_DEN_W-1:0] den_q;
  side_t                side_q;

  assign mag_d    = d1_q[32] ? 33'(-d1_q) : 33'(d1_q);
  assign mag_r    = r1_q[32] ? 33'(-r1_q) : 33'(r1_q);
  assign dneg     = d1_q[32];
  assign dpos     = !d1_q[32] && (d1_q != '0);
  assign rzero    = (r1_q == '0);
  assign num_base = DIV_NUM_W'(mag_d);

  always_comb begin
    side_d.bypass  = 1'b1;
    side_d.byp_val = x1_q;
    side_d.fault   = 1'b0;
    side_d.kind    = KIND_LIN;
    side_d.neg     = d1_q[32] ^ r1_q[32];
    num_d          = num_base << SHIFT_LIN;
    unique case (mode_e'(mode1_q))
      MODE_LINEAR: begin
        if (!ident1_q) begin
          side_d.bypass = rzero;
          side_d.fault  = rzero;
          side_d.byp_val = dpos ? S32_MAX : (dneg ? S32_MIN : '0);
        end
      end
      MODE_SIGMOID, MODE_DSIG: begin
        side_d.kind    = KIND_SIG;
        side_d.bypass  = rzero;
        side_d.fault   = rzero;
        side_d.byp_val = dpos ? Q_ONE : (dneg ? '0 : Q_HALF);
        num_d          = num_base << SHIFT_SIG;
      end
      MODE_ZSCORE, MODE_IQZ: begin
        side_d.kind    = KIND_Z;
        side_d.bypass  = rzero;
        side_d.fault   = rzero;
        side_d.byp_val = dpos ? S32_MAX : (dneg ? S32_MIN : Q_HALF);
        num_d          = num_base << SHIFT_Z;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= mag_r;
    side_q <= side_d;
  end

  assign valid_o = v2_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

@@ src/fnorm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module fnorm_div import fnorm_pkg::*; #(
  parameter int NUM_W  = DIV_NUM_W,
  parameter int DEN_W  = DIV_DEN_W,
  parameter int SIDE_W = SIDE_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quot_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_q [NUM_W];
  logic [NUM_W-1:0]  nq_q    [NUM_W];
  logic [DEN_W-1:0]  rem_q   [NUM_W];
  logic [DEN_W-1:0]  den_q   [NUM_W];
  logic [SIDE_W-1:0] side_q  [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic              v_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DEN_W-1:0]  rem_in, den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial, diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign nq_in   = num_i;
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[i-1];
      assign nq_in   = nq_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      nq_q[i]   <= {nq_in[NUM_W-2:0], ge};
      rem_q[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      den_q[i]  <= den_in;
      side_q[i] <= side_in;
    end
  end

  assign valid_o = valid_q[NUM_W-1];
  assign quot_o  = nq_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

@@ src/fnorm_exp.sv @@
// Pipelined exp(-u) by bit products, then reciprocal operands.
`timescale 1ns / 1ps
module fnorm_exp import fnorm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  mid_t                 mid_i,
  output logic                 valid_o,
  output mid_t                 mid_o,
  output logic [REC_DEN_W-1:0] den_o,
  output logic [48:0]          num_o
);

  logic        valid_q [EXP_BITS];
  logic [32:0] e_q     [EXP_BITS];
  mid_t        mid_q   [EXP_BITS];

  for (genvar b = 0; b < EXP_BITS; b++) begin : g_stage
    logic        v_in;
    logic [32:0] e_in;
    mid_t        m_in;
    logic [64:0] prod;

    if (b == 0) begin : g_first
      assign v_in = valid_i;
      assign e_in = 33'h1_0000_0000;
      assign m_in = mid_i;
    end else begin : g_next
      assign v_in = valid_q[b-1];
      assign e_in = e_q[b-1];
      assign m_in = mid_q[b-1];
    end

    assign prod = 65'(e_in) * 65'(EXP_TAB[b]) + 65'h0_8000_0000;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[b] <= 1'b0;
      end else begin
        valid_q[b] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      e_q[b]   <= m_in.u[b] ? prod[64:32] : e_in;
      mid_q[b] <= m_in;
    end
  end

  logic                 vo_q;
  mid_t                 mo_q;
  logic [REC_DEN_W-1:0] den_q, den_d;
  logic [48:0]          num_q;

  assign den_d = REC_DEN_W'(34'h1_0000_0000 + 34'(e_q[EXP_BITS-1]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= valid_q[EXP_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    mo_q  <= mid_q[EXP_BITS-1];
    den_q <= den_d;
    num_q <= 49'h1_0000_0000_0000 + 49'(den_d[REC_DEN_W-1:1]);
  end

  assign valid_o = vo_q;
  assign mid_o   = mo_q;
  assign den_o   = den_q;
  assign num_o   = num_q;

endmodule

@@ src/feature_normalizer_unit.sv @@
// Top level of the feature normalizer: registers, pipeline and output stage.
// Every mode takes the same path from start to result strobe.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The 52-stage quotient divider sets the depth, followed by 21 exp stages
// and a 17-stage reciprocal divider.
// Reset clears valid bits and gives the config registers their reset values.
`timescale 1ns / 1ps
module feature_normalizer_unit import fnorm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] sample_value_i,
  output logic        result_valid_o,
  output logic [31:0] normalized_value_o,
  output logic        divide_fault_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t                 cfg;
  logic                 fv;
  logic [DIV_NUM_W-1:0] fnum;
  logic [DIV_DEN_W-1:0] fden;
  side_t                fside;
  logic                 dv;
  logic [DIV_NUM_W-1:0] dquot;
  logic [SIDE_BITS-1:0] dside_raw;
  side_t                dside;

  assign busy = 1'b0;

  fnorm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fnorm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start && !busy),
    .sample_i (signed'(sample_value_i)),
    .cfg_i    (cfg),
    .valid_o  (fv),
    .num_o    (fnum),
    .den_o    (fden),
    .side_o   (fside)
  );

  fnorm_div #(
    .NUM_W  (DIV_NUM_W),
    .DEN_W  (DIV_DEN_W),
    .SIDE_W (SIDE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv),
    .num_i   (fnum),
    .rem_i   ('0),
    .den_i   (fden),
    .side_i  (fside),
    .valid_o (dv),
    .quot_o  (dquot),
    .side_o  (dside_raw)
  );

  assign dside = side_t'(dside_raw);

  // post-divide: sign, offset, saturate, sigmoid argument
  logic signed [53:0] sq, sv;
  mid_t               mid_d, mid_q;
  logic               mv_q;

  assign sq = dside.neg ? -54'(dquot) : 54'(dquot);

  always_comb begin
    sv           = (dside.kind == KIND_Z) ? (sq + 54'sd32768) : sq;
    mid_d.fin    = dside.bypass || (dside.kind != KIND_SIG);
    mid_d.fault  = dside.fault;
    mid_d.tneg   = dside.neg && (dquot != '0);
    mid_d.u      = (dquot > DIV_NUM_W'(U_LIMIT)) ? U_LIMIT : dquot[20:0];
    if (dside.bypass) begin
      mid_d.val = dside.byp_val;
    end else if (sv > 54'(S32_MAX)) begin
      mid_d.val = S32_MAX;
    end else if (sv < 54'(S32_MIN)) begin
      mid_d.val = S32_MIN;
    end else begin
      mid_d.val = sv[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
  end

  logic                 ev;
  mid_t                 emid;
  logic [REC_DEN_W-1:0] eden;
  logic [48:0]          enum_w;

  fnorm_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mv_q),
    .mid_i   (mid_q),
    .valid_o (ev),
    .mid_o   (emid),
    .den_o   (eden),
    .num_o   (enum_w)
  );

  logic                 rv;
  logic [REC_NUM_W-1:0] rquot;
  logic [$bits(mid_t)-1:0] rside_raw;
  mid_t                 rmid;

  fnorm_div #(
    .NUM_W  (REC_NUM_W),
    .DEN_W  (REC_DEN_W),
    .SIDE_W ($bits(mid_t))
  ) u_rec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ev),
    .num_i   (enum_w[REC_NUM_W-1:0]),
    .rem_i   (REC_DEN_W'(enum_w[48:REC_NUM_W])),
    .den_i   (eden),
    .side_i  (emid),
    .valid_o (rv),
    .quot_o  (rquot),
    .side_o  (rside_raw)
  );

  assign rmid = mid_t'(rside_raw);

  logic        out_v_q;
  logic [31:0] out_val_q, out_val_d, pext;
  logic        out_f_q;

  assign pext      = 32'(rquot);
  assign out_val_d = rmid.fin ? rmid.val : (rmid.tneg ? (Q_ONE - pext) : pext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= rv;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q <= out_val_d;
    out_f_q   <= rmid.fault;
  end

  assign result_valid_o     = out_v_q;
  assign normalized_value_o = out_val_q;
  assign divide_fault_o     = out_f_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, LATENCY))
    else $error("result strobe without an item accepted 95 cycles earlier");

  a_fault_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && divide_fault_o) |->
      (normalized_value_o == S32_MAX || normalized_value_o == S32_MIN ||
       normalized_value_o == '0 || normalized_value_o == Q_HALF ||
       normalized_value_o == Q_ONE))
    else $error("fault item carries a non-saturated value");

  a_sigmoid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv && !rmid.fin) |-> (rquot <= REC_NUM_W'(Q_ONE)))
    else $error("reciprocal quotient above one");
`endif

endmodule
